>>> hdl/vlbp_pkg.sv
// Shared types and constants for the variable length bit packer.
// No dependencies; imported by every module of the block.
package vlbp_pkg;

   localparam int DEFAULT_WORD_BITS = 32;
   localparam int OUT_WORD_BITS     = 32;
   localparam int BYTE_COUNT_BITS   = 3;
   localparam int NBITS_BITS        = 6;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QPTR_BITS         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS         = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_PUT   = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   // Classified item as held in the queue: length saturated, value masked
   typedef struct packed {
      opcode_type                 opcode;
      logic [NBITS_BITS-1:0]      nbits;
      logic [OUT_WORD_BITS-1:0]   code_value;
   } item_type;

   // Back end activity, for checks at the top level
   typedef struct packed {
      logic pop;
      logic emit;
   } back_status_type;

endpackage

>>> hdl/vlbp_front.sv
// Front end: classifies an incoming item (length saturation, value masking).
// Depends on vlbp_pkg.
module vlbp_front
   import vlbp_pkg::*;
#(
   parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_opcode,
   input  logic [NBITS_BITS-1:0]    req_nbits,
   input  logic [OUT_WORD_BITS-1:0] req_code_value,
   input  logic                     q_full,
   output logic                     q_push,
   output item_type                 q_item
);

   logic [NBITS_BITS-1:0] nbits_sat;

   always_comb begin
      // lengths above the word width saturate to the word width
      if ({1'b0, req_nbits} > (NBITS_BITS+1)'(WORD_BITS)) begin
         nbits_sat = NBITS_BITS'(WORD_BITS);
      end else begin
         nbits_sat = req_nbits;
      end
   end

   always_comb begin
      q_item.opcode     = opcode_type'(req_opcode);
      q_item.nbits      = nbits_sat;
      // shift of 32 or more gives an all-ones mask
      q_item.code_value = req_code_value & ~({OUT_WORD_BITS{1'b1}} << nbits_sat);
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule

>>> hdl/vlbp_queue.sv
// Short queue between front and back ends, registered entries.
// Depends on vlbp_pkg.
module vlbp_queue
   import vlbp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  item_type             push_item,
   input  logic                 pop,
   output logic                 q_valid,
   output logic                 q_full,
   output item_type             head_item,
   output logic [QCNT_BITS-1:0] q_count
);

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = entry_ff[rd_ptr_ff];
   assign q_valid   = (count_ff != '0);
   assign q_full    = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign q_count   = count_ff;

endmodule

>>> hdl/vlbp_back.sv
// Back end: accumulator, free-bit counter and the result register.
// Depends on vlbp_pkg.
module vlbp_back
   import vlbp_pkg::*;
#(
   parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  item_type                   head_item,
   output back_status_type            status,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [OUT_WORD_BITS-1:0]   rsp_out_word,
   output logic [BYTE_COUNT_BITS-1:0] rsp_byte_count
);

   localparam int FW = $clog2(WORD_BITS + 1);
   localparam int CW = ((FW > NBITS_BITS) ? FW : NBITS_BITS) + 1;
   localparam int XW = WORD_BITS + OUT_WORD_BITS;
   localparam logic [BYTE_COUNT_BITS-1:0] FULL_BYTES = BYTE_COUNT_BITS'(WORD_BITS / 8);

   logic [WORD_BITS-1:0]       acc_ff,  acc_in;
   logic [FW-1:0]              free_ff, free_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_WORD_BITS-1:0]   word_ff, word_in;
   logic [BYTE_COUNT_BITS-1:0] bytes_ff, bytes_in;

   logic [CW-1:0]        n_ext, free_ext, spill_ext, pending_ext;
   logic [FW-1:0]        spill;
   logic [XW-1:0]        value_ext, word_ext;
   logic [WORD_BITS-1:0] word_calc;
   logic                 has_result, pop, slot_free;

   always_comb begin
      n_ext       = CW'(head_item.nbits);
      free_ext    = CW'(free_ff);
      spill_ext   = n_ext - free_ext;
      spill       = spill_ext[FW-1:0];
      pending_ext = CW'(WORD_BITS) - free_ext;
      value_ext   = XW'(head_item.code_value);
      // shifting by the full word width clears it
      word_calc   = (acc_ff << free_ff)
                  | WORD_BITS'(value_ext >> spill);
      word_ext    = XW'(word_calc);
   end

   always_comb begin
      if (head_item.opcode == OP_FLUSH) begin
         has_result = (free_ff != FW'(WORD_BITS));
      end else begin
         has_result = (n_ext >= free_ext);
      end
      slot_free = !rsp_valid_ff || rsp_ready;
      pop       = q_valid && (!has_result || slot_free);
   end

   always_comb begin
      acc_in   = acc_ff;
      free_in  = free_ff;
      word_in  = word_ff;
      bytes_in = bytes_ff;
      if (pop) begin
         if (head_item.opcode == OP_FLUSH) begin
            // the flush item's own value and length play no part
            if (has_result) begin
               word_in  = OUT_WORD_BITS'(acc_ff << free_ff);
               bytes_in = BYTE_COUNT_BITS'((pending_ext + CW'(7)) >> 3);
            end
            acc_in   = '0;
            free_in  = FW'(WORD_BITS);
         end else if (has_result) begin
            word_in  = OUT_WORD_BITS'(word_ext);
            bytes_in = FULL_BYTES;
            acc_in   = WORD_BITS'(value_ext) & ~({WORD_BITS{1'b1}} << spill);
            free_in  = FW'(WORD_BITS) - spill;
         end else begin
            acc_in   = (acc_ff << head_item.nbits) | WORD_BITS'(value_ext);
            free_in  = free_ff - FW'(n_ext);
         end
      end
   end

   always_comb begin
      if (pop && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         free_ff      <= FW'(WORD_BITS);
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      bytes_ff <= bytes_in;
   end

   assign status.pop      = pop;
   assign status.emit     = pop && has_result;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_word    = word_ff;
   assign rsp_byte_count  = bytes_ff;

endmodule

>>> hdl/variable_length_bit_packer_unit.sv
// MSB-first variable length bit packer, top level.
// An accepted item is registered in a queue entry, then its result in the result register.
// The back end retires one queued item per cycle
// while the result register is free or being drained.
// Reset (synchronous, active high): queue empty, accumulator zero, all bits free,
// no result pending.
module variable_length_bit_packer_unit
   import vlbp_pkg::*;
#(
   parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_opcode,
   input  logic [NBITS_BITS-1:0]      req_nbits,
   input  logic [OUT_WORD_BITS-1:0]   req_code_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [OUT_WORD_BITS-1:0]   rsp_out_word,
   output logic [BYTE_COUNT_BITS-1:0] rsp_byte_count
);

   logic                 q_full, q_push, q_valid;
   item_type             push_item, head_item;
   logic [QCNT_BITS-1:0] q_count;
   back_status_type      back_status;

   vlbp_front #(
      .WORD_BITS(WORD_BITS)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_nbits      (req_nbits),
      .req_code_value (req_code_value),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   vlbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (back_status.pop),
      .q_valid   (q_valid),
      .q_full    (q_full),
      .head_item (head_item),
      .q_count   (q_count)
   );

   vlbp_back #(
      .WORD_BITS(WORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .head_item      (head_item),
      .status         (back_status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_word   (rsp_out_word),
      .rsp_byte_count (rsp_byte_count)
   );

   // queue never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue over-filled");

   // back end never retires an item from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      q_count == '0 |-> !back_status.pop)
      else $error("pop from empty queue");

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !back_status.emit)
      else $error("result overwritten while stalled");

   // reset leaves the queue empty and no result pending
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (q_count == '0 && !rsp_valid))
      else $error("state not cleared by reset");

endmodule
